@@ src/mgmc_pkg.sv @@
// Shared types, constants and codes for the monotone grid min-congestion path block.
`timescale 1ns / 1ps
package mgmc_pkg;

  localparam int MAX_SPAN    = 32;
  localparam int GRID_STRIDE = 32;
  localparam int AXIS_W      = $clog2(GRID_STRIDE);
  localparam int CELL_DEPTH  = GRID_STRIDE * GRID_STRIDE;
  localparam int CELL_AW     = 2 * AXIS_W;
  localparam int COST_DEPTH  = 2 * GRID_STRIDE;
  localparam int COST_AW     = AXIS_W + 1;
  localparam int PATH_DEPTH  = 2 * GRID_STRIDE - 1;
  localparam int PATH_AW     = $clog2(PATH_DEPTH);
  localparam int COORD_W     = 10;
  localparam int CAP_W       = 4;
  localparam int COST_W      = 10;

  localparam logic [COST_W-1:0] COST_NONE = '1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_TARGET_X  = 3'd2;
  localparam logic [2:0] REG_TARGET_Y  = 3'd3;
  localparam logic [2:0] REG_CAP_LIMIT = 3'd4;

  typedef enum logic [1:0] {
    PAR_NONE = 2'd0,
    PAR_UP   = 2'd1,
    PAR_LEFT = 2'd2,
    PAR_ROOT = 2'd3
  } par_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_TRACE_RD,
    ST_TRACE_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

  typedef struct packed {
    logic        command;
    logic [4:0]  cell_dx;
    logic [4:0]  cell_dy;
    logic        cell_usable;
    logic [3:0]  remaining_capacity;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  path_x;
    logic [9:0]  path_y;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic              is_origin;
    logic              is_target;
    logic              usable;
    logic [CAP_W-1:0]  capacity;
    logic [CAP_W-1:0]  limit;
    logic [COST_W-1:0] up_cost;
    logic [COST_W-1:0] left_cost;
    logic              prefer_up;
  } relax_in_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    par_t              parent;
  } relax_out_t;

endpackage

@@ src/mgmc_relax.sv @@
// Cell relaxation: penalty, neighbor choice with tie rule, new cost and parent code.
`timescale 1ns / 1ps
module mgmc_relax (
  input  mgmc_pkg::relax_in_t  relax_in,
  output mgmc_pkg::relax_out_t relax_out
);
  import mgmc_pkg::*;

  logic              up_ok;
  logic              left_ok;
  logic              choose_up;
  logic [CAP_W-1:0]  pen;
  logic [COST_W-1:0] base;

  always_comb begin
    up_ok     = (relax_in.up_cost != COST_NONE);
    left_ok   = (relax_in.left_cost != COST_NONE);
    pen       = (relax_in.capacity < relax_in.limit) ? relax_in.limit - relax_in.capacity
                                                     : '0;
    choose_up = up_ok && (!left_ok || (relax_in.up_cost < relax_in.left_cost) ||
                ((relax_in.up_cost == relax_in.left_cost) && relax_in.prefer_up));
    base      = choose_up ? relax_in.up_cost : relax_in.left_cost;

    if (relax_in.is_origin) begin
      relax_out.cost   = '0;
      relax_out.parent = PAR_ROOT;
    end else if ((!relax_in.is_target && !relax_in.usable) || (!up_ok && !left_ok)) begin
      relax_out.cost   = COST_NONE;
      relax_out.parent = PAR_NONE;
    end else begin
      relax_out.cost   = base + COST_W'(pen);
      relax_out.parent = choose_up ? PAR_UP : PAR_LEFT;
    end
  end

endmodule

@@ src/monotone_grid_min_congestion_path_top.sv @@
// Top level: config registers, window/parent/cost/path memories, search sequencer.
// A cell load writes the window memory; in_ready is high whenever the block is idle.
// A search sweeps the window one cell per cycle through the cost memory, traces back one
// path cell per parent memory read and check, then emits results via emit read, load and
// hold states, stalling on out_ready; a bad-window failure or single-cell result leaves
// in the cycle after accept. Reset clears control state and config registers; memories are not cleared.
`timescale 1ns / 1ps
module monotone_grid_min_congestion_path_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mgmc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mgmc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [9:0]          cfg_data
);
  import mgmc_pkg::*;

  state_t state;
  state_t state_next;

  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] target_x;
  logic [COORD_W-1:0] target_y;
  logic [CAP_W-1:0]   cap_limit;

  logic [4:0]          cell_mem [CELL_DEPTH];
  par_t                par_mem  [CELL_DEPTH];
  logic [COST_W-1:0]   cost_mem [COST_DEPTH];
  logic [CELL_AW-1:0]  path_mem [PATH_DEPTH];

  logic [4:0]          cell_rd;
  par_t                par_rd;
  logic [COST_W-1:0]   cost_rd;
  logic [CELL_AW-1:0]  path_rd;

  logic [AXIS_W-1:0]   span_x;
  logic [AXIS_W-1:0]   span_y;
  logic [AXIS_W-1:0]   sx;
  logic [AXIS_W-1:0]   sy;
  logic [AXIS_W-1:0]   bx;
  logic [AXIS_W-1:0]   by;
  logic                b_valid;
  logic [COST_W-1:0]   left_cost;
  logic                fwd_hit;
  logic [COST_W-1:0]   fwd_cost;
  logic [AXIS_W-1:0]   cx;
  logic [AXIS_W-1:0]   cy;
  logic [PATH_AW-1:0]  n_cnt;
  logic [PATH_AW-1:0]  e_idx;

  logic [COORD_W-1:0]  diff_x;
  logic [COORD_W-1:0]  diff_y;
  logic                bad_window;
  logic                single_cell;
  logic                in_fire;
  logic                search_fire;
  logic                sweep_last;
  logic                at_origin;
  logic                trace_fail;

  logic                sweep_issue;
  logic                path_we;

  relax_in_t           relax_in;
  relax_out_t          relax_out;

  assign cfg_ready   = 1'b1;
  assign in_fire     = in_valid && in_ready;
  assign search_fire = in_fire && (in_data.command == CMD_SEARCH);
  assign diff_x      = target_x - origin_x;
  assign diff_y      = target_y - origin_y;
  assign bad_window  = (target_x < origin_x) || (target_y < origin_y) ||
                       (diff_x >= COORD_W'(MAX_SPAN)) || (diff_y >= COORD_W'(MAX_SPAN));
  assign single_cell = (diff_x == '0) && (diff_y == '0);
  assign sweep_last  = (sx == span_x) && (sy == span_y);
  assign at_origin   = (cx == '0) && (cy == '0);
  assign trace_fail  = (n_cnt == '0) && (par_rd == PAR_NONE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (search_fire) begin
          state_next = (bad_window || single_cell) ? ST_EMIT_HOLD : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:    state_next = ST_TRACE_RD;
      ST_TRACE_RD: state_next = ST_TRACE_CHK;
      ST_TRACE_CHK: begin
        if (trace_fail) begin
          state_next = ST_EMIT_HOLD;
        end else if (at_origin) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_TRACE_RD;
        end
      end
      ST_EMIT_RD:  state_next = ST_EMIT_LD;
      ST_EMIT_LD:  state_next = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (out_ready) begin
          state_next = out_data.last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    sweep_issue = 1'b0;
    path_we     = 1'b0;
    case (state)
      ST_IDLE:      in_ready    = 1'b1;
      ST_SWEEP:     sweep_issue = 1'b1;
      ST_TRACE_CHK: path_we     = 1'b1;
      ST_EMIT_HOLD: out_valid   = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      target_x  <= '0;
      target_y  <= '0;
      cap_limit <= CAP_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:  origin_x  <= cfg_data;
        REG_ORIGIN_Y:  origin_y  <= cfg_data;
        REG_TARGET_X:  target_x  <= cfg_data;
        REG_TARGET_Y:  target_y  <= cfg_data;
        REG_CAP_LIMIT: cap_limit <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.command == CMD_LOAD)) begin
      cell_mem[{in_data.cell_dy, in_data.cell_dx}] <=
        {in_data.cell_usable, in_data.remaining_capacity};
    end
    cell_rd <= cell_mem[{sy, sx}];
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      cost_mem[{by[0], bx}] <= relax_out.cost;
    end
    cost_rd <= cost_mem[{~sy[0], sx}];
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      par_mem[{by, bx}] <= relax_out.parent;
    end
    par_rd <= par_mem[{cy, cx}];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[n_cnt] <= {cy, cx};
    end
    path_rd <= path_mem[e_idx];
  end

  always_comb begin
    relax_in.is_origin = (bx == '0) && (by == '0);
    relax_in.is_target = (bx == span_x) && (by == span_y);
    relax_in.usable    = cell_rd[4];
    relax_in.capacity  = cell_rd[3:0];
    relax_in.limit     = cap_limit;
    relax_in.up_cost   = (by == '0) ? COST_NONE : (fwd_hit ? fwd_cost : cost_rd);
    relax_in.left_cost = (bx == '0) ? COST_NONE : left_cost;
    relax_in.prefer_up = ~(bx[0] ^ by[0] ^ origin_y[0] ^ target_x[0]);
  end

  mgmc_relax u_relax (
    .relax_in  (relax_in),
    .relax_out (relax_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= sweep_issue;
    end
  end

  always_ff @(posedge clk) begin
    bx       <= sx;
    by       <= sy;
    fwd_hit  <= b_valid && ({by[0], bx} == {~sy[0], sx});
    fwd_cost <= relax_out.cost;
    if (b_valid) begin
      left_cost <= relax_out.cost;
    end

    if (search_fire) begin
      span_x <= diff_x[AXIS_W-1:0];
      span_y <= diff_y[AXIS_W-1:0];
      sx     <= '0;
      sy     <= '0;
      cx     <= diff_x[AXIS_W-1:0];
      cy     <= diff_y[AXIS_W-1:0];
      n_cnt  <= '0;
      if (bad_window) begin
        out_data <= '{found: 1'b0, path_x: '0, path_y: '0, last: 1'b1};
      end else begin
        out_data <= '{found: 1'b1, path_x: origin_x, path_y: origin_y, last: 1'b1};
      end
    end

    if (sweep_issue) begin
      if (sx == span_x) begin
        sx <= '0;
        sy <= sy + AXIS_W'(1);
      end else begin
        sx <= sx + AXIS_W'(1);
      end
    end

    if (state == ST_TRACE_CHK) begin
      n_cnt <= n_cnt + PATH_AW'(1);
      if (trace_fail) begin
        out_data <= '{found: 1'b0, path_x: '0, path_y: '0, last: 1'b1};
      end else if (at_origin) begin
        e_idx <= n_cnt;
      end else if (par_rd == PAR_UP) begin
        cy <= cy - AXIS_W'(1);
      end else if (par_rd == PAR_LEFT) begin
        cx <= cx - AXIS_W'(1);
      end
    end

    if (state == ST_EMIT_LD) begin
      out_data <= '{found:  1'b1,
                    path_x: origin_x + COORD_W'(path_rd[AXIS_W-1:0]),
                    path_y: origin_y + COORD_W'(path_rd[CELL_AW-1:AXIS_W]),
                    last:   (e_idx == '0)};
    end

    if ((state == ST_EMIT_HOLD) && out_ready && !out_data.last) begin
      e_idx <= e_idx - PATH_AW'(1);
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> out_data.last)
    else $error("failure item not marked last");

  a_sweep_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> ((sx <= span_x) && (sy <= span_y)))
    else $error("sweep left the window");

  a_trace_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRACE_CHK) |-> (n_cnt < PATH_AW'(PATH_DEPTH)))
    else $error("traceback longer than path buffer");

  a_sweep_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> b_valid)
    else $error("drain without a cell in flight");

endmodule
